FILE: hdl/tlpt_pkg.sv
// Shared constants and types for the two-level page table updater.
package tlpt_pkg;

  localparam int FRAMES    = 64;
  localparam int ENTRIES   = 1024;
  localparam int IDX_W     = 10;
  localparam int FRAME_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int ADDR_W    = FRAME_W + IDX_W;
  localparam int MEM_DEPTH = FRAMES * ENTRIES;

  localparam int DATA_W    = 32;
  localparam int VPAGE_W   = 20;
  localparam int PFRAME_W  = 20;
  localparam int DFRAME_W  = 6;
  localparam int COUNT_W   = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;
  localparam logic [DFRAME_W-1:0] ALLOC_BASE_RST = 6'd16;

  typedef enum logic [1:0] {
    KIND_MAP   = 2'd0,
    KIND_UNMAP = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FRAME = 2'd1,
    ST_RANGE    = 2'd2,
    ST_RSVD     = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_DIR = 1'd1;

endpackage

FILE: hdl/two_level_page_table_updater.sv
// Top level: page memory, table allocator and map/unmap sequencer.
//
//  channel | direction | handshake         | payload
//  in_     | input     | in_valid/in_stall  | kind, dir_frame, virtual_page, phys_frame,
//          |           |                    | attr_*, word_index, write_data
//  out_    | output    | out_valid/out_stall| status, table_allocated, tlb_flush, read_data
//  cfg_    | input     | cfg_valid/cfg_ready| index, data
//
//  One beat at a time. A word write goes from S_ISSUE to the result register; a word read,
//  unmap and map into an existing table also pass S_DECIDE, and a map that allocates a
//  table clears all 1024 words of the new frame through the single memory write port.
//  After reset the page memory is swept to zero, all FRAMES*ENTRIES words (65536),
//  with in_stall high. A new beat is taken while a result waits under out_stall.
module two_level_page_table_updater (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_kind,
  input  logic [tlpt_pkg::DFRAME_W-1:0]      in_dir_frame,
  input  logic [tlpt_pkg::VPAGE_W-1:0]       in_virtual_page,
  input  logic [tlpt_pkg::PFRAME_W-1:0]      in_phys_frame,
  input  logic                               in_attr_present,
  input  logic                               in_attr_rw,
  input  logic                               in_attr_user,
  input  logic [tlpt_pkg::IDX_W-1:0]         in_word_index,
  input  logic [tlpt_pkg::DATA_W-1:0]        in_write_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_status,
  output logic                               out_table_allocated,
  output logic                               out_tlb_flush,
  output logic [tlpt_pkg::DATA_W-1:0]        out_read_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tlpt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tlpt_pkg::DFRAME_W-1:0]      cfg_data
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ISSUE,
    S_DECIDE,
    S_ZERO,
    S_LINK,
    S_PTE,
    S_DONE
  } state_t;

  state_t                              state_r;
  logic [tlpt_pkg::ADDR_W-1:0]         clr_addr_r;
  logic [tlpt_pkg::IDX_W-1:0]          zero_idx_r;
  logic [tlpt_pkg::COUNT_W-1:0]        alloc_count_r;
  logic [tlpt_pkg::DFRAME_W-1:0]       alloc_base_r;
  logic [tlpt_pkg::DFRAME_W-1:0]       active_dir_r;

  tlpt_pkg::kind_t                     kind_r;
  logic [tlpt_pkg::DFRAME_W-1:0]       dir_r;
  logic [tlpt_pkg::VPAGE_W-1:0]        vpage_r;
  logic [tlpt_pkg::PFRAME_W-1:0]       pframe_r;
  logic                                ap_r;
  logic                                arw_r;
  logic                                aus_r;
  logic [tlpt_pkg::IDX_W-1:0]          widx_r;
  logic [tlpt_pkg::DATA_W-1:0]         wdata_r;
  logic [tlpt_pkg::FRAME_W-1:0]        tbl_frame_r;

  tlpt_pkg::status_t                   res_status_r;
  logic                                res_alloc_r;
  logic                                res_flush_r;
  logic [tlpt_pkg::DATA_W-1:0]         res_rdata_r;

  logic                                out_valid_r;
  logic [1:0]                          out_status_r;
  logic                                out_alloc_r;
  logic                                out_flush_r;
  logic [tlpt_pkg::DATA_W-1:0]         out_rdata_r;

  logic [tlpt_pkg::DATA_W-1:0]         mem [tlpt_pkg::MEM_DEPTH];
  logic [tlpt_pkg::DATA_W-1:0]         mem_q_r;
  logic                                mem_we;
  logic [tlpt_pkg::ADDR_W-1:0]         mem_waddr;
  logic [tlpt_pkg::DATA_W-1:0]         mem_wdata;
  logic                                mem_re;
  logic [tlpt_pkg::ADDR_W-1:0]         mem_raddr;

  logic                                dir_ok;
  logic                                active;
  logic                                pde_present;
  logic                                tf_ok;
  logic [tlpt_pkg::FRAME_W-1:0]        pde_frame;
  logic [tlpt_pkg::FRAME_W-1:0]        dir_frame;
  logic [tlpt_pkg::DFRAME_W+1:0]       nf_sum;
  logic                                exhausted;
  logic [tlpt_pkg::IDX_W-1:0]          dir_idx;
  logic [tlpt_pkg::IDX_W-1:0]          tbl_idx;
  logic [tlpt_pkg::DATA_W-1:0]         pte_data;
  logic [tlpt_pkg::DATA_W-1:0]         pde_data;

  assign in_stall            = (state_r != S_IDLE);
  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_table_allocated = out_alloc_r;
  assign out_tlb_flush       = out_flush_r;
  assign out_read_data       = out_rdata_r;

  assign dir_ok      = 32'(dir_r) < tlpt_pkg::FRAMES;
  assign active      = (dir_r == active_dir_r);
  assign dir_frame   = tlpt_pkg::FRAME_W'(dir_r);
  assign pde_present = mem_q_r[0];
  assign tf_ok       = 32'(mem_q_r[31:12]) < tlpt_pkg::FRAMES;
  assign pde_frame   = tlpt_pkg::FRAME_W'(mem_q_r[31:12]);
  assign nf_sum      = {2'b00, alloc_base_r} + {1'b0, alloc_count_r};
  assign exhausted   = (alloc_count_r >= tlpt_pkg::COUNT_MAX) ||
                       (32'(nf_sum) >= tlpt_pkg::FRAMES);
  assign dir_idx     = vpage_r[19:10];
  assign tbl_idx     = vpage_r[9:0];
  assign pte_data    = (kind_r == tlpt_pkg::KIND_MAP) ?
                       {pframe_r, 9'b0, aus_r, arw_r, ap_r} : '0;
  assign pde_data    = {tlpt_pkg::PFRAME_W'(tbl_frame_r), 9'b0, 3'b111};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_r;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = {dir_frame, dir_idx};
    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_ISSUE: begin
        if (dir_ok && kind_r == tlpt_pkg::KIND_WRITE) begin
          mem_we    = 1'b1;
          mem_waddr = {dir_frame, widx_r};
          mem_wdata = wdata_r;
        end
        mem_re = dir_ok && (kind_r != tlpt_pkg::KIND_WRITE);
        if (kind_r == tlpt_pkg::KIND_READ) begin
          mem_raddr = {dir_frame, widx_r};
        end
      end
      S_ZERO: begin
        mem_we    = 1'b1;
        mem_waddr = {tbl_frame_r, zero_idx_r};
      end
      S_LINK: begin
        mem_we    = 1'b1;
        mem_waddr = {dir_frame, dir_idx};
        mem_wdata = pde_data;
      end
      S_PTE: begin
        mem_we    = 1'b1;
        mem_waddr = {tbl_frame_r, tbl_idx};
        mem_wdata = pte_data;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_addr_r    <= '0;
      alloc_count_r <= '0;
      alloc_base_r  <= tlpt_pkg::ALLOC_BASE_RST;
      active_dir_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          tlpt_pkg::CFG_ALLOC_BASE: alloc_base_r <= cfg_data;
          tlpt_pkg::CFG_ACTIVE_DIR: active_dir_r <= cfg_data;
          default: begin
          end
        endcase
      end

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == tlpt_pkg::ADDR_W'(tlpt_pkg::MEM_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            kind_r   <= tlpt_pkg::kind_t'(in_kind);
            dir_r    <= in_dir_frame;
            vpage_r  <= in_virtual_page;
            pframe_r <= in_phys_frame;
            ap_r     <= in_attr_present;
            arw_r    <= in_attr_rw;
            aus_r    <= in_attr_user;
            widx_r   <= in_word_index;
            wdata_r  <= in_write_data;
            state_r  <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          res_status_r <= tlpt_pkg::ST_OK;
          res_alloc_r  <= 1'b0;
          res_flush_r  <= 1'b0;
          res_rdata_r  <= '0;
          if (!dir_ok) begin
            res_status_r <= tlpt_pkg::ST_RANGE;
            state_r      <= S_DONE;
          end else if (kind_r == tlpt_pkg::KIND_WRITE) begin
            res_flush_r <= active;
            state_r     <= S_DONE;
          end else begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state_r <= S_DONE;
          unique case (kind_r)
            tlpt_pkg::KIND_READ: begin
              res_rdata_r <= mem_q_r;
            end
            tlpt_pkg::KIND_MAP: begin
              if (!pde_present) begin
                if (exhausted) begin
                  res_status_r <= tlpt_pkg::ST_NO_FRAME;
                end else begin
                  tbl_frame_r   <= tlpt_pkg::FRAME_W'(nf_sum);
                  zero_idx_r    <= '0;
                  alloc_count_r <= alloc_count_r + 1'b1;
                  res_alloc_r   <= 1'b1;
                  state_r       <= S_ZERO;
                end
              end else if (!tf_ok) begin
                res_status_r <= tlpt_pkg::ST_RANGE;
              end else begin
                tbl_frame_r <= pde_frame;
                state_r     <= S_PTE;
              end
            end
            tlpt_pkg::KIND_UNMAP: begin
              if (pde_present) begin
                if (!tf_ok) begin
                  res_status_r <= tlpt_pkg::ST_RANGE;
                end else begin
                  tbl_frame_r <= pde_frame;
                  state_r     <= S_PTE;
                end
              end
            end
            default: begin
            end
          endcase
        end
        S_ZERO: begin
          zero_idx_r <= zero_idx_r + 1'b1;
          if (&zero_idx_r) begin
            state_r <= S_LINK;
          end
        end
        S_LINK: begin
          state_r <= S_PTE;
        end
        S_PTE: begin
          res_flush_r <= active;
          state_r     <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_alloc_r  <= res_alloc_r;
            out_flush_r  <= res_flush_r;
            out_rdata_r  <= res_rdata_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/tlpt_checker.sv
// Port-level checks for the two-level page table updater, bound to the top level.
module tlpt_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [1:0]                         out_status,
  input  logic                               out_table_allocated,
  input  logic                               out_tlb_flush,
  input  logic [tlpt_pkg::DATA_W-1:0]        out_read_data
);

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != tlpt_pkg::ST_OK) |-> !out_table_allocated && !out_tlb_flush)
    else $error("error result carries allocate or flush");

  a_rdata_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_read_data != '0) |-> (out_status == tlpt_pkg::ST_OK) && !out_tlb_flush)
    else $error("read data on a failed or modifying beat");

  a_alloc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_allocated |-> (out_read_data == '0))
    else $error("allocating map returned read data");

  a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken while one is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind two_level_page_table_updater tlpt_checker u_tlpt_checker (.*);

FILE: tb/sv/tb_two_level_page_table_updater.sv
// Self-checking testbench for the two-level page table updater.
module tb_two_level_page_table_updater;

  localparam logic [31:0] PTE_PRESENT = 32'h1;
  localparam logic [31:0] PTE_RW      = 32'h2;
  localparam logic [31:0] PTE_USER    = 32'h4;
  localparam int PHASES = 5;

  typedef struct packed {
    tlpt_pkg::kind_t                kind;
    logic [tlpt_pkg::DFRAME_W-1:0]  dframe;
    logic [tlpt_pkg::VPAGE_W-1:0]   vpage;
    logic [tlpt_pkg::PFRAME_W-1:0]  pframe;
    logic                           ap;
    logic                           arw;
    logic                           aus;
    logic [tlpt_pkg::IDX_W-1:0]     widx;
    logic [tlpt_pkg::DATA_W-1:0]    wdata;
  } req_t;

  typedef struct packed {
    tlpt_pkg::status_t              status;
    logic                           table_alloc;
    logic                           flush;
    logic [tlpt_pkg::DATA_W-1:0]    read_data;
  } resp_t;

  typedef struct packed {
    req_t  req;
    logic  typed;
    resp_t want;
  } dir_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [1:0]                      in_kind = '0;
  logic [tlpt_pkg::DFRAME_W-1:0]   in_dir_frame = '0;
  logic [tlpt_pkg::VPAGE_W-1:0]    in_virtual_page = '0;
  logic [tlpt_pkg::PFRAME_W-1:0]   in_phys_frame = '0;
  logic                            in_attr_present = 1'b0;
  logic                            in_attr_rw = 1'b0;
  logic                            in_attr_user = 1'b0;
  logic [tlpt_pkg::IDX_W-1:0]      in_word_index = '0;
  logic [tlpt_pkg::DATA_W-1:0]     in_write_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [1:0]                      out_status;
  logic                            out_table_allocated;
  logic                            out_tlb_flush;
  logic [tlpt_pkg::DATA_W-1:0]     out_read_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [tlpt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tlpt_pkg::DFRAME_W-1:0]   cfg_data = '0;

  bit [tlpt_pkg::DATA_W-1:0]       shadow_mem [tlpt_pkg::MEM_DEPTH];
  logic [tlpt_pkg::COUNT_W-1:0]    alloc_cnt = '0;
  logic [tlpt_pkg::DFRAME_W-1:0]   cur_alloc_base = tlpt_pkg::ALLOC_BASE_RST;
  logic [tlpt_pkg::DFRAME_W-1:0]   cur_active_dir = '0;
  resp_t                           pending_results [$];
  int                              errors = 0;
  int                              burst_left = 0;
  int                              stall_left = 0;
  int                              stall_mode = 0;

  logic [tlpt_pkg::DFRAME_W-1:0] phase_base   [PHASES] = '{16, 0, 63, 40, 5};
  logic [tlpt_pkg::DFRAME_W-1:0] phase_active [PHASES] = '{0, 63, 1, 2, 16};

  dir_row_t dir_rows [20] = '{
    '{'{tlpt_pkg::KIND_READ,   0, 'h00000, 'h00000, 0, 0, 0,    0, 'h0}, 1,
      '{tlpt_pkg::ST_OK, 0, 0, 'h0}},
    '{'{tlpt_pkg::KIND_READ,  63, 'h00000, 'h00000, 0, 0, 0, 1023, 'h0}, 1,
      '{tlpt_pkg::ST_OK, 0, 0, 'h0}},
    '{'{tlpt_pkg::KIND_MAP,    0, 'h00000, 'hFFFFF, 1, 1, 1,    0, 'h0}, 1,
      '{tlpt_pkg::ST_OK, 1, 1, 'h0}},
    '{'{tlpt_pkg::KIND_READ,   0, 'h00000, 'h00000, 0, 0, 0,    0, 'h0}, 1,
      '{tlpt_pkg::ST_OK, 0, 0, 'h00010007}},
    '{'{tlpt_pkg::KIND_READ,  16, 'h00000, 'h00000, 0, 0, 0,    0, 'h0}, 1,
      '{tlpt_pkg::ST_OK, 0, 0, 'hFFFFF007}},
    '{'{tlpt_pkg::KIND_MAP,    0, 'h003FF, 'h00000, 0, 0, 0,    0, 'h0}, 0,
      '{tlpt_pkg::ST_OK, 0, 0, 'h0}},
    '{'{tlpt_pkg::KIND_UNMAP,  0, 'h00000, 'h00000, 0, 0, 0,    0, 'h0}, 1,
      '{tlpt_pkg::ST_OK, 0, 1, 'h0}},
    '{'{tlpt_pkg::KIND_READ,  16, 'h00000, 'h00000, 0, 0, 0,    0, 'h0}, 1,
      '{tlpt_pkg::ST_OK, 0, 0, 'h0}},
    '{'{tlpt_pkg::KIND_UNMAP,  5, 'hFFFFF, 'h00000, 0, 0, 0,    0, 'h0}, 1,
      '{tlpt_pkg::ST_OK, 0, 0, 'h0}},
    '{'{tlpt_pkg::KIND_MAP,    5, 'hFFFFF, 'h12345, 1, 0, 1,    0, 'h0}, 0,
      '{tlpt_pkg::ST_OK, 0, 0, 'h0}},
    '{'{tlpt_pkg::KIND_READ,  17, 'h00000, 'h00000, 0, 0, 0, 1023, 'h0}, 0,
      '{tlpt_pkg::ST_OK, 0, 0, 'h0}},
    '{'{tlpt_pkg::KIND_MAP,    5, 'hFFFFE, 'hABCDE, 0, 1, 0,    0, 'h0}, 0,
      '{tlpt_pkg::ST_OK, 0, 0, 'h0}},
    '{'{tlpt_pkg::KIND_READ,  17, 'h00000, 'h00000, 0, 0, 0, 1022, 'h0}, 0,
      '{tlpt_pkg::ST_OK, 0, 0, 'h0}},
    '{'{tlpt_pkg::KIND_WRITE,  0, 'h00000, 'h00000, 0, 0, 0,    7, 'hFFFFFFFF}, 1,
      '{tlpt_pkg::ST_OK, 0, 1, 'h0}},
    '{'{tlpt_pkg::KIND_WRITE, 63, 'h00000, 'h00000, 0, 0, 0, 1023, 'h00040001}, 1,
      '{tlpt_pkg::ST_OK, 0, 0, 'h0}},
    '{'{tlpt_pkg::KIND_MAP,   63, 'hFFC00, 'h00001, 1, 0, 0,    0, 'h0}, 1,
      '{tlpt_pkg::ST_RANGE, 0, 0, 'h0}},
    '{'{tlpt_pkg::KIND_UNMAP, 63, 'hFFC00, 'h00000, 0, 0, 0,    0, 'h0}, 1,
      '{tlpt_pkg::ST_RANGE, 0, 0, 'h0}},
    '{'{tlpt_pkg::KIND_READ,  63, 'h00000, 'h00000, 0, 0, 0, 1023, 'h0}, 1,
      '{tlpt_pkg::ST_OK, 0, 0, 'h00040001}},
    '{'{tlpt_pkg::KIND_READ,   0, 'h00000, 'h00000, 0, 0, 0,    7, 'h0}, 1,
      '{tlpt_pkg::ST_OK, 0, 0, 'hFFFFFFFF}},
    '{'{tlpt_pkg::KIND_WRITE,  2, 'h00000, 'h00000, 0, 0, 0,  512, 'h0}, 1,
      '{tlpt_pkg::ST_OK, 0, 0, 'h0}}
  };

  two_level_page_table_updater dut (.*);

  always #10 clk = ~clk;

  function automatic int word_addr(input int frame, input int idx);
    return frame * tlpt_pkg::ENTRIES + idx;
  endfunction

  function automatic resp_t apply_request(input req_t r);
    resp_t         res;
    logic [31:0]   pde;
    int            tf;
    int            nf;
    int            pde_at;
    bit            active;
    res = '{tlpt_pkg::ST_OK, 1'b0, 1'b0, '0};
    active = (r.dframe == cur_active_dir);
    pde_at = word_addr(int'(r.dframe), int'(r.vpage[19:10]));
    if (int'(r.dframe) >= tlpt_pkg::FRAMES) begin
      res.status = tlpt_pkg::ST_RANGE;
    end else begin
      case (r.kind)
        tlpt_pkg::KIND_WRITE: begin
          shadow_mem[word_addr(int'(r.dframe), int'(r.widx))] = r.wdata;
          res.flush = active;
        end
        tlpt_pkg::KIND_READ: begin
          res.read_data = shadow_mem[word_addr(int'(r.dframe), int'(r.widx))];
        end
        tlpt_pkg::KIND_MAP: begin
          pde = shadow_mem[pde_at];
          if (!pde[0]) begin
            nf = int'(cur_alloc_base) + int'(alloc_cnt);
            if (alloc_cnt >= tlpt_pkg::COUNT_MAX || nf >= tlpt_pkg::FRAMES) begin
              res.status = tlpt_pkg::ST_NO_FRAME;
            end else begin
              for (int w = 0; w < tlpt_pkg::ENTRIES; w++) shadow_mem[word_addr(nf, w)] = '0;
              alloc_cnt = alloc_cnt + 1'b1;
              pde = (32'(nf) << 12) | PTE_PRESENT | PTE_RW | PTE_USER;
              shadow_mem[pde_at] = pde;
              res.table_alloc = 1'b1;
            end
          end
          if (res.status == tlpt_pkg::ST_OK) begin
            tf = int'(pde[31:12]);
            if (tf >= tlpt_pkg::FRAMES) begin
              res.status = tlpt_pkg::ST_RANGE;
              res.table_alloc = 1'b0;
            end else begin
              shadow_mem[word_addr(tf, int'(r.vpage[9:0]))] =
                {r.pframe, 9'd0, r.aus, r.arw, r.ap};
              res.flush = active;
            end
          end
        end
        default: begin
          pde = shadow_mem[pde_at];
          if (pde[0]) begin
            tf = int'(pde[31:12]);
            if (tf >= tlpt_pkg::FRAMES) begin
              res.status = tlpt_pkg::ST_RANGE;
            end else begin
              shadow_mem[word_addr(tf, int'(r.vpage[9:0]))] = '0;
              res.flush = active;
            end
          end
        end
      endcase
    end
    return res;
  endfunction

  function automatic logic [tlpt_pkg::DFRAME_W-1:0] pick_dir_frame();
    case ($urandom_range(9, 0))
      0, 1, 2, 3, 4: return cur_active_dir;
      5, 6, 7, 8:    return tlpt_pkg::DFRAME_W'($urandom_range(3, 0));
      default:       return tlpt_pkg::DFRAME_W'($urandom);
    endcase
  endfunction

  function automatic logic [tlpt_pkg::IDX_W-1:0] pick_dir_index();
    case ($urandom_range(7, 0))
      0, 1, 2, 3, 4: return tlpt_pkg::IDX_W'($urandom_range(3, 0));
      5:             return tlpt_pkg::IDX_W'(tlpt_pkg::ENTRIES - 1);
      default:       return tlpt_pkg::IDX_W'($urandom);
    endcase
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   roll;
    roll = $urandom_range(99, 0);
    r.kind = tlpt_pkg::kind_t'($urandom_range(3, 0));
    r.dframe = tlpt_pkg::DFRAME_W'($urandom);
    r.vpage = tlpt_pkg::VPAGE_W'($urandom);
    r.pframe = tlpt_pkg::PFRAME_W'($urandom);
    r.ap = 1'($urandom);
    r.arw = 1'($urandom);
    r.aus = 1'($urandom);
    r.widx = tlpt_pkg::IDX_W'($urandom);
    r.wdata = $urandom;
    if (roll >= 10) begin
      r.dframe = pick_dir_frame();
      r.vpage[19:10] = pick_dir_index();
      if ($urandom_range(1, 0) == 0) r.vpage[9:0] = tlpt_pkg::IDX_W'($urandom_range(7, 0));
      if (roll < 50) begin
        r.kind = tlpt_pkg::KIND_MAP;
      end else if (roll < 70) begin
        r.kind = tlpt_pkg::KIND_UNMAP;
      end else if (roll < 85) begin
        r.kind = tlpt_pkg::KIND_WRITE;
        r.widx = pick_dir_index();
        if ($urandom_range(1, 0) == 0)
          r.wdata = {13'd0, 7'($urandom_range(80, 0)), 9'd0, 3'($urandom) | 3'b001};
      end else begin
        r.kind = tlpt_pkg::KIND_READ;
        if (roll < 93)
          r.dframe = tlpt_pkg::DFRAME_W'(cur_alloc_base + $urandom_range(7, 0));
        if ($urandom_range(1, 0) == 0) r.widx = pick_dir_index();
      end
    end
    return r;
  endfunction

  task automatic issue(input req_t r, input logic typed, input resp_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(20, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_kind         <= r.kind;
    in_dir_frame    <= r.dframe;
    in_virtual_page <= r.vpage;
    in_phys_frame   <= r.pframe;
    in_attr_present <= r.ap;
    in_attr_rw      <= r.arw;
    in_attr_user    <= r.aus;
    in_word_index   <= r.widx;
    in_write_data   <= r.wdata;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (typed) begin
      void'(apply_request(r));
      pending_results.push_back(want);
    end else begin
      pending_results.push_back(apply_request(r));
    end
  endtask

  task automatic write_register(input logic [tlpt_pkg::CFG_IDX_W-1:0] idx,
                                input logic [tlpt_pkg::DFRAME_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == tlpt_pkg::CFG_ALLOC_BASE) cur_alloc_base = val;
    else cur_active_dir = val;
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // receiver: alternate between free running, light, heavy and long holds
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(3, 0);
      stall_left <= $urandom_range(60, 5);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(3, 0) == 0);
      2:       out_stall <= ($urandom_range(1, 0) == 0);
      default: out_stall <= (stall_left > 8);
    endcase
  end

  always @(posedge clk) begin : result_check
    resp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, status %0d", $time, out_status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
          errors++;
        end
        if (out_table_allocated !== want.table_alloc) begin
          $display("%0t: table_allocated expected %0b got %0b", $time, want.table_alloc,
                   out_table_allocated);
          errors++;
        end
        if (out_tlb_flush !== want.flush) begin
          $display("%0t: tlb_flush expected %0b got %0b", $time, want.flush, out_tlb_flush);
          errors++;
        end
        if (out_read_data !== want.read_data) begin
          $display("%0t: read_data expected %h got %h", $time, want.read_data,
                   out_read_data);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_register(tlpt_pkg::CFG_ALLOC_BASE, phase_base[p]);
      write_register(tlpt_pkg::CFG_ACTIVE_DIR, phase_active[p]);
      cfg_valid <= 1'b0;
      if (p == 0) begin
        foreach (dir_rows[i]) issue(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
      end
      for (int i = 0; i < ((p == 0) ? 130 : 150); i++) issue(random_request(), 1'b0, '0);
      in_valid <= 1'b0;
    end
    for (int c = 0; c < 100000 && pending_results.size() != 0; c++) @(posedge clk);
    repeat (1100) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
